>>> sv/assert_macros.svh
// Assertion macros for a file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/rcq_pkg.sv
// Types and constants shared by the evictor controller and datapath.
package rcq_pkg;
  localparam int MAX_RESULTS = 8;
  localparam int RES_BITS    = 4;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_READ   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_UNLINK = 7'b0001000,
    ST_APPEND = 7'b0010000,
    ST_EVICT  = 7'b0100000,
    ST_EVFIX  = 7'b1000000
  } rcq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic read;
    logic decide;
    logic unlink;
    logic append;
    logic evict;
    logic evfix;
  } rcq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_unlink;
    logic go_append;
    logic go_evict;
    logic more_evict;
  } rcq_sts_t;
endpackage

>>> sv/rcq_ctrl.sv
// Controller state machine of the evictor.
module rcq_ctrl import rcq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output rcq_cmd_t cmd,
  input  rcq_sts_t sts
);
  rcq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.go_unlink) state_nxt = ST_UNLINK;
        else if (sts.go_append) state_nxt = ST_APPEND;
        else state_nxt = ST_IDLE;
      end
      ST_UNLINK: begin
        state_nxt = ST_IDLE;
      end
      ST_APPEND: begin
        state_nxt = sts.go_evict ? ST_EVICT : ST_IDLE;
      end
      ST_EVICT: begin
        state_nxt = ST_EVFIX;
      end
      ST_EVFIX: begin
        state_nxt = sts.more_evict ? ST_EVICT : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.latch  = (state_r == ST_IDLE) && start;
  assign cmd.read   = (state_r == ST_READ);
  assign cmd.decide = (state_r == ST_DECIDE);
  assign cmd.unlink = (state_r == ST_UNLINK);
  assign cmd.append = (state_r == ST_APPEND);
  assign cmd.evict  = (state_r == ST_EVICT);
  assign cmd.evfix  = (state_r == ST_EVFIX);
endmodule

>>> sv/rcq_dp.sv
// Datapath of the evictor: count and link memories, queue registers, results.
module rcq_dp import rcq_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_operation,
  input  logic [5:0]  in_entry_index,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  rcq_cmd_t    cmd,
  output rcq_sts_t    sts,
  output logic        out_valid,
  output logic        out_evicted_valid,
  output logic [5:0]  out_evicted_entry,
  output logic [15:0] out_use_count_after,
  output logic [6:0]  out_unused_length,
  output logic        out_error,
  output logic        out_last
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  // Memories: counts, links; queue membership in flip-flops (reset cleared).
  logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
  logic [IW-1:0] nxt_mem [ENTRIES];
  logic [IW-1:0] prv_mem [ENTRIES];
  logic [ENTRIES-1:0] inq_r;
  logic [ENTRIES-1:0] cvld_r;

  logic [6:0] max_r;
  logic [IW-1:0] head_r, tail_r;
  logic [LW-1:0] len_r;
  logic op_r, oor_r;
  logic [IW-1:0] e_r;
  logic [COUNT_BITS-1:0] crd_r, cnew_r;
  logic [IW-1:0] nrd_r, prd_r;
  logic [RES_BITS-1:0] k_r;
  logic [6:0] low_r;
  logic err_r;

  logic [COUNT_BITS-1:0] cnt_cur;
  logic [IW-1:0] mem_addr;
  logic [15:0] cnt16;
  logic [23:0] low_calc;
  logic [LW-1:0] len_dec;
  logic [7:0] len_w;
  logic [LW-1:0] len_app;

  logic go_un_c, go_ap_c, emit_c, ev_c;
  logic [COUNT_BITS-1:0] cn_c;
  logic er_c, upd_c;

  assign cnt_cur  = cvld_r[e_r] ? crd_r : '0;
  assign mem_addr = cmd.evict ? head_r : e_r;
  assign cnt16    = 16'(cnew_r);
  // Low watermark floor(9*max/10) by a reciprocal multiplication (6554/65536).
  assign low_calc = 24'(max_r) * 24'd9 * 24'd6554;
  assign len_dec  = (len_r != '0) ? len_r - 1'b1 : len_r;
  assign len_w    = 8'(len_r);
  assign len_app  = len_r + 1'b1;

  // Head link is read in the evict cycle, used in the fix cycle.
  always_ff @(posedge clk) begin
    crd_r <= cnt_mem[mem_addr];
    nrd_r <= nxt_mem[mem_addr];
    prd_r <= prv_mem[mem_addr];
    if (cmd.decide && upd_c) cnt_mem[e_r] <= cn_c;
    if (cmd.unlink) begin
      if (e_r != head_r) nxt_mem[prd_r] <= nrd_r;
      if (e_r != tail_r) prv_mem[nrd_r] <= prd_r;
    end
    if (cmd.append && len_r != '0) begin
      nxt_mem[tail_r] <= e_r;
      prv_mem[e_r]    <= tail_r;
    end
    if (cmd.evfix && head_r != tail_r) prv_mem[nrd_r] <= prd_r;
  end

  // Decision on the step, from the count read in the read cycle.
  always_comb begin
    er_c = 1'b0; upd_c = 1'b0; cn_c = cnt_cur;
    go_un_c = 1'b0; go_ap_c = 1'b0; ev_c = 1'b0; emit_c = 1'b1;
    if (oor_r) begin
      er_c = 1'b1; cn_c = '0;
    end else if (!op_r) begin
      if (cnt_cur == CMAX) begin
        er_c = 1'b1;
      end else begin
        cn_c = cnt_cur + 1'b1; upd_c = 1'b1;
        go_un_c = (cnt_cur == '0) && inq_r[e_r];
        emit_c = !go_un_c;
      end
    end else begin
      if (cnt_cur == '0) begin
        er_c = 1'b1;
      end else begin
        cn_c = cnt_cur - 1'b1; upd_c = 1'b1;
        if (cn_c == '0) begin
          if (max_r == '0) ev_c = 1'b1;
          else begin go_ap_c = 1'b1; emit_c = 1'b0; end
        end
      end
    end
  end

  assign sts.go_unlink  = go_un_c;
  assign sts.go_append  = go_ap_c;
  assign sts.go_evict   = (8'(len_app) > 8'(max_r));
  assign sts.more_evict = (k_r + 1'b1 != RES_BITS'(MAX_RESULTS)) &&
                          (8'(len_dec) > 8'(low_r)) && (len_dec != '0);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_operation;
      oor_r <= (32'(in_entry_index) >= 32'(ENTRIES));
      e_r   <= IW'(in_entry_index);
    end
    if (cmd.decide) begin
      cnew_r <= cn_c;
      err_r  <= er_c;
    end
    if (cmd.append) begin
      k_r   <= '0;
      low_r <= low_calc[22:16];
    end
    if (cmd.evfix) k_r <= k_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= 7'd64;
      inq_r  <= '0;
      cvld_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      len_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) max_r <= cfg_wdata;
      if (cmd.decide) begin
        if (upd_c) cvld_r[e_r] <= 1'b1;
        if (emit_c) begin
          out_valid           <= 1'b1;
          out_evicted_valid   <= ev_c;
          out_evicted_entry   <= ev_c ? 6'(e_r) : 6'd0;
          out_use_count_after <= 16'(cn_c);
          out_unused_length   <= 7'(len_w);
          out_error           <= er_c;
          out_last            <= 1'b1;
        end
      end
      if (cmd.unlink) begin
        if (e_r == head_r) head_r <= nrd_r;
        if (e_r == tail_r) tail_r <= prd_r;
        inq_r[e_r] <= 1'b0;
        len_r <= len_dec;
        out_valid           <= 1'b1;
        out_evicted_valid   <= 1'b0;
        out_evicted_entry   <= 6'd0;
        out_use_count_after <= cnt16;
        out_unused_length   <= 7'(8'(len_dec));
        out_error           <= 1'b0;
        out_last            <= 1'b1;
      end
      if (cmd.append) begin
        if (len_r == '0) head_r <= e_r;
        tail_r <= e_r;
        inq_r[e_r] <= 1'b1;
        len_r <= len_app;
        if (!sts.go_evict) begin
          out_valid           <= 1'b1;
          out_evicted_valid   <= 1'b0;
          out_evicted_entry   <= 6'd0;
          out_use_count_after <= cnt16;
          out_unused_length   <= 7'(8'(len_app));
          out_error           <= 1'b0;
          out_last            <= 1'b1;
        end
      end
      if (cmd.evfix) begin
        // Remove the head; its next link is in nrd_r.
        if (head_r == tail_r) tail_r <= prd_r;
        head_r <= nrd_r;
        inq_r[head_r] <= 1'b0;
        len_r <= len_dec;
        out_valid           <= 1'b1;
        out_evicted_valid   <= 1'b1;
        out_evicted_entry   <= 6'(head_r);
        out_use_count_after <= cnt16;
        out_unused_length   <= 7'(8'(len_dec));
        out_error           <= err_r;
        out_last            <= !((k_r + 1'b1 != RES_BITS'(MAX_RESULTS)) &&
                                (8'(len_dec) > 8'(low_r)) && (len_dec != '0));
      end
    end
  end
endmodule

>>> sv/refcount_unused_queue_evictor_top.sv
// Top level of the use-counted entry evictor with an unused queue.
// The block keeps a use count per cache entry and a queue of unused entries.
// A request beat is taken on a clock edge where start is high and busy low:
// in_operation 0 acquires, 1 releases the entry in_entry_index.
// Every request gives one or more result beats, each shown for exactly one
// cycle with out_valid high; out_last marks the final beat of a request.
// A plain request is busy while it passes through the read and decide states
// and its result beat is registered as it leaves decide, so a new request
// can be taken only once the block is idle again; an acquire that unlinks from
// the queue or a release that appends also passes through the unlink or append state.
// Each eviction reads the head's link from the link memory in the evict state
// and unlinks the head in the evfix state.
// Eviction stops at the low watermark, floor(9*max/10), or after eight beats.
// cfg_we with cfg_wdata writes max_unused; the user must write only while the block idles (not enforced).
// Reset (synchronous, rst_n low) empties the queue, clears every count via
// per-entry valid bits and sets max_unused to 64; no clearing pass is needed.
// The receiver cannot stall: result beats are presented once and must be
// taken on the cycle they appear.
`include "assert_macros.svh"
module refcount_unused_queue_evictor_top import rcq_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [5:0]  in_entry_index,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output logic        out_valid,
  output logic        out_evicted_valid,
  output logic [5:0]  out_evicted_entry,
  output logic [15:0] out_use_count_after,
  output logic [6:0]  out_unused_length,
  output logic        out_error,
  output logic        out_last
);
  rcq_cmd_t cmd;
  rcq_sts_t sts;

  // The controller sequences each request; the datapath owns all storage.
  rcq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  rcq_dp #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_operation(in_operation), .in_entry_index(in_entry_index),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_evicted_valid(out_evicted_valid),
    .out_evicted_entry(out_evicted_entry),
    .out_use_count_after(out_use_count_after),
    .out_unused_length(out_unused_length),
    .out_error(out_error), .out_last(out_last)
  );

  // A request is never accepted while a result beat is still to come.
  `CHK_IMPL(a_no_accept_busy, clk, rst_n, cmd.latch, !busy, "accept while busy")
  // An eviction beat always carries a clean error flag in a queue run.
  `CHK_IMPL(a_evict_ok, clk, rst_n, out_valid && out_evicted_valid, !out_error, "evict error")
  // The block is already idle while the final result beat is shown.
  `CHK_IMPL(a_idle_at_last, clk, rst_n, out_valid && out_last, !busy, "busy at last beat")
endmodule
